### src/zip_directory_locator_top_macros.svh
// Concurrent check helpers for the directory locator
`ifndef ZIP_DIRECTORY_LOCATOR_TOP_MACROS_SVH
`define ZIP_DIRECTORY_LOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define ZDL_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ZDL_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/zdl_pkg.sv
package zdl_pkg;

   localparam int MEM_BYTES  = 65536;
   localparam int ADDR_W     = $clog2(MEM_BYTES);
   localparam int SIZE_W     = 17;
   localparam int OFF_W      = 36;
   localparam int NAME_LIMIT = 255;

   localparam logic [31:0] EOCD_SIG = 32'h06054b50;
   localparam logic [31:0] CDIR_SIG = 32'h02014b50;
   localparam logic [31:0] LOCH_SIG = 32'h04034b50;
   localparam int EOCD_LEN = 22;
   localparam int CDIR_LEN = 46;
   localparam int LOCH_LEN = 30;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_MOUNT  = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SMALL    = 2'd1;
   localparam logic [1:0] ST_NO_END   = 2'd2;
   localparam logic [1:0] ST_BAD      = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] address;
      logic [7:0]  byte_value;
      logic [15:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] entry_count;
      logic [15:0] method;
      logic [31:0] zipped_size;
      logic [31:0] uncomp_size;
      logic [15:0] data_offset;
      logic [15:0] name_offset;
      logic [7:0]  name_length;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } ctrl_type;

endpackage

### src/zip_directory_locator_top.sv
// Channel | Direction | Handshake        | Payload
// req     | in        | req_valid/stall  | req_data (req_type)
// rsp     | out       | rsp_valid/stall  | rsp_data (rsp_type)
// csr     | in        | csr_valid/ready  | csr_data (blob_size, 17 bits)
//
// Load writes the byte when the request is accepted. A field read passes
// S_RD_START for its bounds check, then S_RD_ISSUE and S_RD_WAIT per byte.
// Mount scans end-record candidates backwards from the image end, reading the
// record fields on a hit; Query skips directory records, then reads the entry.
// Synchronous active-high reset; no clearing pass. A result waits in the
// output register while rsp_stall is high; the next transaction starts meanwhile.
`include "zip_directory_locator_top_macros.svh"

module zip_directory_locator_top
   import zdl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data
);

   logic [SIZE_W-1:0] blob_size_ff, lim;
   logic              rsp_valid_ff, start, ack;
   rsp_type           rsp_data_ff, result;
   ctrl_type          ctrl;

   assign lim       = (blob_size_ff > SIZE_W'(MEM_BYTES)) ? SIZE_W'(MEM_BYTES) : blob_size_ff;
   assign req_stall = !ctrl.idle;
   assign start     = req_valid && ctrl.idle;
   assign ack       = ctrl.done && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   zdl_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .lim    (lim),
      .ack    (ack),
      .ctrl   (ctrl),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         blob_size_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            blob_size_ff <= csr_data;
         end
         if (ack) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= result;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ZDL_CHECK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accept did not start work")
   `ZDL_CHECK_NEXT(a_result_loaded, ack, rsp_valid, "finished transaction not presented")
   `ZDL_CHECK(a_small_no_count, rsp_valid && rsp_data.status == ST_SMALL, rsp_data.entry_count == 16'd0, "failed mount kept a count")

endmodule

### src/zdl_image_mem.sv
module zdl_image_mem
   import zdl_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [MEM_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/zdl_walker.sv
module zdl_walker
   import zdl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req,
   input  logic [SIZE_W-1:0] lim,
   input  logic              ack,
   output ctrl_type          ctrl,
   output rsp_type           result
);

   typedef enum logic [4:0] {
      S_IDLE, S_RD_START, S_RD_ISSUE, S_RD_WAIT,
      S_M_BEGIN, S_M_SIG, S_M_NEXT, S_M_CNT, S_M_SZ, S_M_OFF, S_M_CHK,
      S_Q_BEGIN, S_Q_WALK, S_Q_SIG, S_Q_A, S_Q_B, S_Q_C,
      S_Q_NL, S_Q_CS, S_Q_LH, S_Q_LSIG, S_Q_LA, S_Q_LB, S_Q_DCHK,
      S_Q_METH, S_Q_USZ, S_DONE
   } state_type;

   state_type         state_ff, ret_ff;
   logic [OFF_W-1:0]  rd_off_ff, p_ff, acc_ff;
   logic [2:0]        rd_n_ff;
   logic [1:0]        rd_cnt_ff;
   logic [31:0]       rd_val_ff, a_ff, b_ff, csize_ff, usize_ff, dir_ff;
   logic [15:0]       cnt_ff, count_ff, k_ff, idx_ff, method_ff;
   logic [7:0]        nl_ff;
   logic [1:0]        status_ff, func_ff;
   logic [OFF_W-1:0]  lim_w, name_end;
   logic [7:0]        nl_clamp, mem_data;
   logic [ADDR_W-1:0] rd_addr;
   logic              ok;

   assign lim_w    = OFF_W'(lim);
   assign nl_clamp = (rd_val_ff[15:0] > 16'(NAME_LIMIT)) ? 8'(NAME_LIMIT) : rd_val_ff[7:0];
   assign name_end = p_ff + OFF_W'(CDIR_LEN) + OFF_W'(nl_clamp);
   assign rd_addr  = rd_off_ff[ADDR_W-1:0] + ADDR_W'(rd_cnt_ff);

   zdl_image_mem u_mem (
      .clock   (clock),
      .wr_en   (start && (req.func == FUNC_LOAD)),
      .wr_addr (req.address[ADDR_W-1:0]),
      .wr_data (req.byte_value),
      .rd_en   (state_ff == S_RD_ISSUE),
      .rd_addr (rd_addr),
      .rd_data (mem_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         dir_ff    <= '0;
         count_ff  <= '0;
         status_ff <= ST_OK;
         func_ff   <= FUNC_LOAD;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff <= req.func;
                  idx_ff  <= req.entry_index;
                  case (req.func)
                     FUNC_LOAD: begin
                        status_ff <= ST_OK;
                        state_ff  <= S_DONE;
                     end
                     FUNC_MOUNT: state_ff <= S_M_BEGIN;
                     FUNC_QUERY: state_ff <= S_Q_BEGIN;
                     default: begin
                        status_ff <= ST_BAD;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end
            S_RD_START: begin
               rd_val_ff <= '0;
               rd_cnt_ff <= '0;
               if (rd_off_ff + OFF_W'(rd_n_ff) > lim_w) begin
                  state_ff <= ret_ff;
               end else begin
                  state_ff <= S_RD_ISSUE;
               end
            end
            S_RD_ISSUE: state_ff <= S_RD_WAIT;
            S_RD_WAIT: begin
               case (rd_cnt_ff)
                  2'd0: rd_val_ff[7:0]   <= mem_data;
                  2'd1: rd_val_ff[15:8]  <= mem_data;
                  2'd2: rd_val_ff[23:16] <= mem_data;
                  default: rd_val_ff[31:24] <= mem_data;
               endcase
               if (3'(rd_cnt_ff) == rd_n_ff - 3'd1) begin
                  state_ff <= ret_ff;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 2'd1;
                  state_ff  <= S_RD_ISSUE;
               end
            end
            S_M_BEGIN: begin
               dir_ff   <= '0;
               count_ff <= '0;
               if (lim < SIZE_W'(EOCD_LEN)) begin
                  status_ff <= ST_SMALL;
                  state_ff  <= S_DONE;
               end else begin
                  p_ff      <= lim_w - OFF_W'(EOCD_LEN);
                  rd_off_ff <= lim_w - OFF_W'(EOCD_LEN);
                  rd_n_ff   <= 3'd4;
                  ret_ff    <= S_M_SIG;
                  state_ff  <= S_RD_START;
               end
            end
            S_M_SIG: begin
               if (rd_val_ff == EOCD_SIG) begin
                  rd_off_ff <= p_ff + OFF_W'(10);
                  rd_n_ff   <= 3'd2;
                  ret_ff    <= S_M_CNT;
                  state_ff  <= S_RD_START;
               end else begin
                  state_ff <= S_M_NEXT;
               end
            end
            S_M_NEXT: begin
               if (p_ff == '0) begin
                  status_ff <= ST_NO_END;
                  state_ff  <= S_DONE;
               end else begin
                  p_ff      <= p_ff - OFF_W'(1);
                  rd_off_ff <= p_ff - OFF_W'(1);
                  rd_n_ff   <= 3'd4;
                  ret_ff    <= S_M_SIG;
                  state_ff  <= S_RD_START;
               end
            end
            S_M_CNT: begin
               cnt_ff    <= rd_val_ff[15:0];
               rd_off_ff <= p_ff + OFF_W'(12);
               rd_n_ff   <= 3'd4;
               ret_ff    <= S_M_SZ;
               state_ff  <= S_RD_START;
            end
            S_M_SZ: begin
               a_ff      <= rd_val_ff;
               rd_off_ff <= p_ff + OFF_W'(16);
               rd_n_ff   <= 3'd4;
               ret_ff    <= S_M_OFF;
               state_ff  <= S_RD_START;
            end
            S_M_OFF: begin
               b_ff     <= rd_val_ff;
               state_ff <= S_M_CHK;
            end
            S_M_CHK: begin
               if ((OFF_W'(b_ff) <= p_ff) && (OFF_W'(b_ff) + OFF_W'(a_ff) <= lim_w)) begin
                  dir_ff    <= b_ff;
                  count_ff  <= cnt_ff;
                  status_ff <= ST_OK;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_M_NEXT;
               end
            end
            S_Q_BEGIN: begin
               if (idx_ff >= count_ff) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  p_ff     <= OFF_W'(dir_ff);
                  k_ff     <= '0;
                  state_ff <= S_Q_WALK;
               end
            end
            S_Q_WALK: begin
               rd_off_ff <= p_ff;
               rd_n_ff   <= 3'd4;
               ret_ff    <= S_Q_SIG;
               state_ff  <= S_RD_START;
            end
            S_Q_SIG: begin
               if (rd_val_ff != CDIR_SIG) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  rd_off_ff <= p_ff + OFF_W'(28);
                  rd_n_ff   <= 3'd2;
                  acc_ff    <= p_ff + OFF_W'(CDIR_LEN);
                  state_ff  <= S_RD_START;
                  if (k_ff == idx_ff) begin
                     ret_ff <= S_Q_NL;
                  end else begin
                     ret_ff <= S_Q_A;
                  end
               end
            end
            S_Q_A: begin
               acc_ff    <= acc_ff + OFF_W'(rd_val_ff[15:0]);
               rd_off_ff <= p_ff + OFF_W'(30);
               rd_n_ff   <= 3'd2;
               ret_ff    <= S_Q_B;
               state_ff  <= S_RD_START;
            end
            S_Q_B: begin
               acc_ff    <= acc_ff + OFF_W'(rd_val_ff[15:0]);
               rd_off_ff <= p_ff + OFF_W'(32);
               rd_n_ff   <= 3'd2;
               ret_ff    <= S_Q_C;
               state_ff  <= S_RD_START;
            end
            S_Q_C: begin
               p_ff     <= acc_ff + OFF_W'(rd_val_ff[15:0]);
               k_ff     <= k_ff + 16'd1;
               state_ff <= S_Q_WALK;
            end
            S_Q_NL: begin
               nl_ff <= nl_clamp;
               if ((nl_clamp != '0) && (name_end > lim_w)) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  rd_off_ff <= p_ff + OFF_W'(20);
                  rd_n_ff   <= 3'd4;
                  ret_ff    <= S_Q_CS;
                  state_ff  <= S_RD_START;
               end
            end
            S_Q_CS: begin
               csize_ff  <= rd_val_ff;
               rd_off_ff <= p_ff + OFF_W'(42);
               rd_n_ff   <= 3'd4;
               ret_ff    <= S_Q_LH;
               state_ff  <= S_RD_START;
            end
            S_Q_LH: begin
               a_ff      <= rd_val_ff;
               rd_off_ff <= OFF_W'(rd_val_ff);
               rd_n_ff   <= 3'd4;
               ret_ff    <= S_Q_LSIG;
               state_ff  <= S_RD_START;
            end
            S_Q_LSIG: begin
               if (rd_val_ff != LOCH_SIG) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  acc_ff    <= OFF_W'(a_ff) + OFF_W'(LOCH_LEN);
                  rd_off_ff <= OFF_W'(a_ff) + OFF_W'(26);
                  rd_n_ff   <= 3'd2;
                  ret_ff    <= S_Q_LA;
                  state_ff  <= S_RD_START;
               end
            end
            S_Q_LA: begin
               acc_ff    <= acc_ff + OFF_W'(rd_val_ff[15:0]);
               rd_off_ff <= OFF_W'(a_ff) + OFF_W'(28);
               rd_n_ff   <= 3'd2;
               ret_ff    <= S_Q_LB;
               state_ff  <= S_RD_START;
            end
            S_Q_LB: begin
               acc_ff   <= acc_ff + OFF_W'(rd_val_ff[15:0]);
               state_ff <= S_Q_DCHK;
            end
            S_Q_DCHK: begin
               if (acc_ff + OFF_W'(csize_ff) > lim_w) begin
                  status_ff <= ST_BAD;
                  state_ff  <= S_DONE;
               end else begin
                  rd_off_ff <= p_ff + OFF_W'(10);
                  rd_n_ff   <= 3'd2;
                  ret_ff    <= S_Q_METH;
                  state_ff  <= S_RD_START;
               end
            end
            S_Q_METH: begin
               method_ff <= rd_val_ff[15:0];
               rd_off_ff <= p_ff + OFF_W'(24);
               rd_n_ff   <= 3'd4;
               ret_ff    <= S_Q_USZ;
               state_ff  <= S_RD_START;
            end
            S_Q_USZ: begin
               usize_ff  <= rd_val_ff;
               status_ff <= ST_OK;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign ok = (status_ff == ST_OK) && (func_ff == FUNC_QUERY);

   always_comb begin
      result             = '0;
      result.status      = status_ff;
      result.entry_count = count_ff;
      if (ok) begin
         result.method      = method_ff;
         result.zipped_size = csize_ff;
         result.uncomp_size = usize_ff;
         result.data_offset = acc_ff[15:0];
         result.name_offset = 16'(p_ff + OFF_W'(CDIR_LEN));
         result.name_length = nl_ff;
      end
   end

   assign ctrl.idle = (state_ff == S_IDLE);
   assign ctrl.done = (state_ff == S_DONE);

endmodule
